// ----- hw/rtl/dpq_pkg.sv -----
// ----------------------------------------------------------------------------
// dpq_pkg: shared types and constants of the double-ended priority queue
// Field widths, command and status codes, and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package dpq_pkg;

  localparam int VAL_W            = 31;
  localparam int CMD_W            = 2;
  localparam int STATUS_W         = 2;
  localparam int CAPACITY_DEFAULT = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 2'd0,
    CMD_EXTRACT_MIN = 2'd1,
    CMD_EXTRACT_MAX = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One operation per cycle goes to every cell of a chain.
  typedef struct packed {
    logic insert;     // place the key in order, shift later part one cell on
    logic pop_head;   // drop cell 0, shift the rest one cell back
    logic drop_tail;  // invalidate the last occupied cell
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/double_ended_priority_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_priority_queue: min/max queue of 31-bit values
// Two sorted cell chains hold the same items; insert and both extracts.
// ----------------------------------------------------------------------------
// Each command passes through a command register and one cell update: a
// transaction is taken when start is high and busy is low, the command sits in
// a register (busy high), and on the next edge every cell of both chains
// updates at once. No new transaction is taken while a command is held. The
// pace is set by the command register and one cell update, not by the fill.
// Insert gives no result unless the queue holds CAPACITY items, in which case
// the value is dropped and status reports full. Each extract, and an insert
// into a full queue, gives exactly one result: done is high for one cycle,
// from the edge that updates the cells, with result_value and status valid
// only in that cycle. The receiver cannot stall it, so capture it then.
// Command code 3 is ignored. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_priority_queue #(
  parameter int CAPACITY = dpq_pkg::CAPACITY_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire  [dpq_pkg::CMD_W-1:0]     cmd,
  input  wire  [dpq_pkg::VAL_W-1:0]     value,
  output logic                          done,
  output logic [dpq_pkg::VAL_W-1:0]     result_value,
  output logic [dpq_pkg::STATUS_W-1:0]  status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Command register
  logic                      pending;
  logic [dpq_pkg::CMD_W-1:0] cmd_q;
  logic [dpq_pkg::VAL_W-1:0] value_q;

  // Queue state
  logic [CNT_W-1:0] item_count;
  logic [CNT_W-1:0] item_count_next;

  // Chain control and heads
  dpq_pkg::cell_ctl_t        asc_ctl;
  dpq_pkg::cell_ctl_t        desc_ctl;
  logic [dpq_pkg::VAL_W-1:0] asc_head;
  logic                      asc_head_valid;
  logic [dpq_pkg::VAL_W-1:0] desc_head;
  logic                      desc_head_valid;

  // Result staging
  logic                         done_next;
  logic [dpq_pkg::VAL_W-1:0]    result_value_next;
  dpq_pkg::status_t             status_next;

  logic accept;
  logic q_full;
  logic q_empty;

  assign busy    = pending;
  assign accept  = start && !busy;
  assign q_full  = (item_count == CNT_W'(CAPACITY));
  assign q_empty = (item_count == '0);

  // Hold the command while the chains get ready to take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      value_q <= value;
    end
  end

  // Decode the held command into cell operations and a result.
  // Extract-min pops the ascending head and drops the descending tail, which
  // holds the same (smallest) value; extract-max is the mirror image.
  always_comb begin
    asc_ctl           = '0;
    desc_ctl          = '0;
    item_count_next   = item_count;
    done_next         = 1'b0;
    result_value_next = '0;
    status_next       = dpq_pkg::ST_OK;
    if (pending) begin
      unique case (cmd_q)
        dpq_pkg::CMD_INSERT: begin
          if (q_full) begin
            done_next   = 1'b1;
            status_next = dpq_pkg::ST_FULL;
          end else begin
            asc_ctl.insert  = 1'b1;
            desc_ctl.insert = 1'b1;
            item_count_next = item_count + CNT_W'(1);
          end
        end
        dpq_pkg::CMD_EXTRACT_MIN: begin
          done_next = 1'b1;
          if (q_empty) begin
            status_next = dpq_pkg::ST_EMPTY;
          end else begin
            result_value_next  = asc_head;
            asc_ctl.pop_head   = 1'b1;
            desc_ctl.drop_tail = 1'b1;
            item_count_next    = item_count - CNT_W'(1);
          end
        end
        dpq_pkg::CMD_EXTRACT_MAX: begin
          done_next = 1'b1;
          if (q_empty) begin
            status_next = dpq_pkg::ST_EMPTY;
          end else begin
            result_value_next = desc_head;
            desc_ctl.pop_head = 1'b1;
            asc_ctl.drop_tail = 1'b1;
            item_count_next   = item_count - CNT_W'(1);
          end
        end
        default: begin
          // Unused code: drop the command without a result.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      done       <= 1'b0;
    end else begin
      item_count <= item_count_next;
      done       <= done_next;
    end
  end

  // Advance the result payload; it is only looked at while done is high.
  always_ff @(posedge clk) begin
    result_value <= result_value_next;
    status       <= status_next;
  end

  // Ascending chain: minimum in cell 0.
  dpq_chain #(
    .DEPTH  (CAPACITY),
    .DESCEND(1'b0)
  ) u_asc (
    .clk       (clk),
    .rst       (rst),
    .ctl       (asc_ctl),
    .key       (value_q),
    .head_value(asc_head),
    .head_valid(asc_head_valid)
  );

  // Descending chain: maximum in cell 0.
  dpq_chain #(
    .DEPTH  (CAPACITY),
    .DESCEND(1'b1)
  ) u_desc (
    .clk       (clk),
    .rst       (rst),
    .ctl       (desc_ctl),
    .key       (value_q),
    .head_value(desc_head),
    .head_valid(desc_head_valid)
  );

  // Both chains hold an item exactly when the count says so.
  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    (asc_head_valid == !q_empty) && (desc_head_valid == !q_empty))
    else $error("chain occupancy disagrees with item count");

  // The smallest item never orders above the largest.
  a_heads_ordered: assert property (@(posedge clk) disable iff (rst)
    asc_head_valid |-> (asc_head <= desc_head))
    else $error("minimum head exceeds maximum head");

  // A result comes only from a command held in the previous cycle.
  a_done_from_command: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pending))
    else $error("result without a held command");

  // An empty report leaves the queue empty.
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    (done && (status == dpq_pkg::ST_EMPTY)) |-> q_empty)
    else $error("empty status with items stored");

endmodule

`default_nettype wire

// ----- hw/rtl/dpq_cell.sv -----
// ----------------------------------------------------------------------------
// dpq_cell: one slot of a sorted chain
// Holds one value and its valid bit; trades data with its two neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_cell #(
  parameter bit DESCEND = 1'b0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  dpq_pkg::cell_ctl_t           ctl,
  input  wire  [dpq_pkg::VAL_W-1:0]    key,
  input  wire  [dpq_pkg::VAL_W-1:0]    left_value,
  input  wire                          left_valid,
  input  wire                          left_stay,
  input  wire  [dpq_pkg::VAL_W-1:0]    right_value,
  input  wire                          right_valid,
  output logic [dpq_pkg::VAL_W-1:0]    value,
  output logic                         valid,
  output logic                         stay
);

  logic [dpq_pkg::VAL_W-1:0] value_next;
  logic                      valid_next;

  // A held item stays put on insert when it orders at or before the key.
  assign stay = valid && (DESCEND ? (value >= key) : (value <= key));

  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctl.insert) begin
      if (!stay) begin
        if (left_stay) begin
          value_next = key;
          valid_next = 1'b1;
        end else begin
          value_next = left_value;
          valid_next = left_valid;
        end
      end
    end else if (ctl.pop_head) begin
      value_next = right_value;
      valid_next = right_valid;
    end else if (ctl.drop_tail) begin
      valid_next = valid && right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dpq_chain.sv -----
// ----------------------------------------------------------------------------
// dpq_chain: row of cells kept in sorted order
// Ascending or descending; the extreme item always sits in cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_chain #(
  parameter int DEPTH   = dpq_pkg::CAPACITY_DEFAULT,
  parameter bit DESCEND = 1'b0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  dpq_pkg::cell_ctl_t           ctl,
  input  wire  [dpq_pkg::VAL_W-1:0]    key,
  output logic [dpq_pkg::VAL_W-1:0]    head_value,
  output logic                         head_valid
);

  logic [dpq_pkg::VAL_W-1:0] cell_value [DEPTH];
  logic                      cell_valid [DEPTH];
  logic                      cell_stay  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dpq_pkg::VAL_W-1:0] lv;
    logic                      lvld;
    logic                      lstay;
    logic [dpq_pkg::VAL_W-1:0] rv;
    logic                      rvld;

    if (i == 0) begin : g_head
      assign lv    = '0;
      assign lvld  = 1'b1;
      assign lstay = 1'b1;
    end else begin : g_body
      assign lv    = cell_value[i-1];
      assign lvld  = cell_valid[i-1];
      assign lstay = cell_stay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_next
      assign rv   = cell_value[i+1];
      assign rvld = cell_valid[i+1];
    end

    dpq_cell #(
      .DESCEND(DESCEND)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (key),
      .left_value (lv),
      .left_valid (lvld),
      .left_stay  (lstay),
      .right_value(rv),
      .right_valid(rvld),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .stay       (cell_stay[i])
    );
  end

  assign head_value = cell_value[0];
  assign head_valid = cell_valid[0];

endmodule

`default_nettype wire

// ----- sim/double_ended_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb: self-checking bench for the min/max queue
// Drives insert and extract transactions over start/busy, mirrors the stored
// multiset as a sorted list, and checks every done strobe against it.
// ----------------------------------------------------------------------------

module double_ended_priority_queue_tb;

  localparam int QUEUE_CAPACITY = dpq_pkg::CAPACITY_DEFAULT;
  // Code 3 has no member in cmd_t; the block must ignore it.
  localparam logic [dpq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 23;
  localparam int RANDOM_ITEMS  = 100;
  localparam int DRAIN_ITEMS   = 32;

  typedef struct packed {
    logic [dpq_pkg::VAL_W-1:0] value;
    dpq_pkg::status_t          status;
  } dpq_result_t;

  // Scoreboard: the queue contents are kept as an ascending list, so the
  // minimum sits at the front and the maximum at the back. Equal values are
  // interchangeable, which is all the cell chains promise.
  class dpq_scoreboard;
    logic [dpq_pkg::VAL_W-1:0] held[$];
    dpq_result_t               awaited[$];
    int errors, checked, peak;
    int n_insert, n_min, n_max, n_ignored, n_full, n_empty;

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    function void note_command(logic [dpq_pkg::CMD_W-1:0] c,
                               logic [dpq_pkg::VAL_W-1:0] v);
      int pos;
      dpq_result_t r;
      r.value  = '0;
      r.status = dpq_pkg::ST_OK;
      case (c)
        dpq_pkg::CMD_INSERT: begin
          n_insert++;
          if (held.size() >= QUEUE_CAPACITY) begin
            // Full: value is dropped and a full status comes back.
            r.status = dpq_pkg::ST_FULL;
            n_full++;
            awaited.push_back(r);
          end else begin
            pos = 0;
            while (pos < held.size() && held[pos] <= v) pos++;
            held.insert(pos, v);
            if (held.size() > peak) peak = held.size();
          end
        end
        dpq_pkg::CMD_EXTRACT_MIN, dpq_pkg::CMD_EXTRACT_MAX: begin
          if (c == dpq_pkg::CMD_EXTRACT_MIN) n_min++;
          else n_max++;
          if (held.size() == 0) begin
            r.status = dpq_pkg::ST_EMPTY;
            n_empty++;
          end else if (c == dpq_pkg::CMD_EXTRACT_MIN) begin
            r.value = held.pop_front();
          end else begin
            r.value = held.pop_back();
          end
          awaited.push_back(r);
        end
        default: n_ignored++;
      endcase
    endfunction

    task check_result(logic [dpq_pkg::VAL_W-1:0] v, logic [dpq_pkg::STATUS_W-1:0] s);
      dpq_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("result with none pending: value=%h status=%0d", v, s));
        return;
      end
      want = awaited.pop_front();
      if (s !== want.status)
        report($sformatf("status %0d, want %0d", s, want.status));
      if (v !== want.value)
        report($sformatf("result_value %h, want %h", v, want.value));
    endtask

    task finish_check();
      if (awaited.size() != 0)
        report($sformatf("%0d results never arrived", awaited.size()));
    endtask
  endclass

  logic                         clk;
  logic                         rst   = 1'b1;
  logic                         start = 1'b0;
  logic [dpq_pkg::CMD_W-1:0]    cmd   = dpq_pkg::CMD_INSERT;
  logic [dpq_pkg::VAL_W-1:0]    value = '0;
  logic                         busy;
  logic                         done;
  logic [dpq_pkg::VAL_W-1:0]    result_value;
  logic [dpq_pkg::STATUS_W-1:0] status;
  int                           cycle_count = 0;

  dpq_scoreboard mirror = new;

  double_ended_priority_queue #(
    .CAPACITY(QUEUE_CAPACITY)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .value       (value),
    .done        (done),
    .result_value(result_value),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, mirror.awaited.size());
      $display("status: fail");
      $finish;
    end
  end

  // Capture each result in its single strobe cycle; the receiver has no
  // way to hold it off, so sample at the edge that ends that cycle.
  always @(posedge clk) begin
    if (!rst && done) mirror.check_result(result_value, status);
  end

  // Issue one transaction. Optionally idle first with start low, then hold
  // start high until an edge sees busy low. Record the command in the
  // scoreboard at the accepting edge, so occupancy is current on return.
  task automatic issue(input logic [dpq_pkg::CMD_W-1:0] c,
                       input logic [dpq_pkg::VAL_W-1:0] v,
                       input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    value <= v;
    do @(posedge clk); while (busy);
    mirror.note_command(c, v);
  endtask

  // Drop start and hold off until every pending result has come back,
  // then let the block settle.
  task automatic wait_quiet();
    start <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mix wide random values with clustered small ones (to force duplicates),
  // the extremes, values near the top, and walking ones.
  function automatic logic [dpq_pkg::VAL_W-1:0] rand_value();
    logic [dpq_pkg::VAL_W-1:0] top;
    top = '1;
    case ($urandom_range(0, 5))
      0, 1:    return dpq_pkg::VAL_W'($urandom);
      2:       return dpq_pkg::VAL_W'($urandom_range(0, 15));
      3:       return $urandom_range(0, 1) ? top : '0;
      4:       return top - dpq_pkg::VAL_W'($urandom_range(0, 15));
      default: return dpq_pkg::VAL_W'(1) << $urandom_range(0, dpq_pkg::VAL_W - 1);
    endcase
  endfunction

  function automatic logic [dpq_pkg::CMD_W-1:0] pick_cmd(input int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_UNUSED;
    if (r < 3 + insert_pct) return dpq_pkg::CMD_INSERT;
    return $urandom_range(0, 1) ? dpq_pkg::CMD_EXTRACT_MIN : dpq_pkg::CMD_EXTRACT_MAX;
  endfunction

  initial begin
    int                        n;
    int                        idle;
    logic [dpq_pkg::CMD_W-1:0] c;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty extracts, field extremes, duplicates, unused code,
    // drain back to empty and extract once more.
    issue(dpq_pkg::CMD_EXTRACT_MIN, '1, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MAX, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, '1, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, 31'h5555_5555, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, 31'h2AAA_AAAA, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, 31'd5, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, 31'd5, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, 31'd5, IDLE_PCT);
    issue(CMD_UNUSED, '1, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MAX, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MIN, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MIN, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MAX, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MAX, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MIN, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MAX, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MIN, '0, IDLE_PCT);
    issue(CMD_UNUSED, '0, IDLE_PCT);
    issue(dpq_pkg::CMD_INSERT, 31'd1, IDLE_PCT);
    issue(dpq_pkg::CMD_EXTRACT_MAX, '1, IDLE_PCT);
    wait_quiet();

    // Random mix: grow the queue in the first half, shrink it in the
    // second; run part of it back to back with no idle cycles.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      idle = (n >= 30 && n < 80) ? 0 : IDLE_PCT;
      c    = pick_cmd(n < RANDOM_ITEMS / 2 ? 56 : 40);
      issue(c, rand_value(), idle);
      if (c != CMD_UNUSED) n++;
    end
    wait_quiet();

    // Fill to capacity with a long back-to-back stretch in the middle,
    // push past it, then take a batch back out of the full queue.
    while (mirror.held.size() < QUEUE_CAPACITY) begin
      idle = (mirror.held.size() >= QUEUE_CAPACITY / 4 &&
              mirror.held.size() < 3 * QUEUE_CAPACITY / 4) ? 0 : IDLE_PCT;
      issue(dpq_pkg::CMD_INSERT, rand_value(), idle);
    end
    repeat (3) issue(dpq_pkg::CMD_INSERT, rand_value(), IDLE_PCT);
    issue(CMD_UNUSED, rand_value(), IDLE_PCT);
    repeat (DRAIN_ITEMS)
      issue($urandom_range(0, 1) ? dpq_pkg::CMD_EXTRACT_MIN : dpq_pkg::CMD_EXTRACT_MAX,
            rand_value(), IDLE_PCT);

    wait_quiet();
    mirror.finish_check();

    $display("covered %0d inserts (%0d refused full), %0d min and %0d max extracts",
             mirror.n_insert, mirror.n_full, mirror.n_min, mirror.n_max);
    $display("%0d empty extracts, %0d ignored codes, peak fill %0d, %0d results checked",
             mirror.n_empty, mirror.n_ignored, mirror.peak, mirror.checked);
    if (mirror.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
